>>> hdl/i2cm_pkg.sv
`timescale 1ns / 1ps

package i2cm_pkg;

	localparam int DIV_WIDTH_DEF = 16;

	localparam int CFG_WIDTH = 16;
	localparam int CFG_INDEX_WIDTH = 1;

	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_HALF_PERIOD = 1'b0;
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ACK_TIMEOUT = 1'b1;

	localparam logic [CFG_WIDTH-1:0] HALF_PERIOD_RST = 16'd4;
	localparam logic [CFG_WIDTH-1:0] ACK_TIMEOUT_RST = 16'd1000;

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_WRITE = 2'd1,
		OP_READ  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	// Byte position within the address/register/data sequence.
	typedef enum logic [1:0] {
		STG_DEV  = 2'd0,
		STG_REG  = 2'd1,
		STG_DATA = 2'd2
	} stage_t;

	typedef enum logic [13:0] {
		PH_IDLE      = 14'b00000000000001,
		PH_START_A   = 14'b00000000000010,
		PH_START_B   = 14'b00000000000100,
		PH_BIT_LOW   = 14'b00000000001000,
		PH_BIT_HIGH  = 14'b00000000010000,
		PH_ACK_LOW   = 14'b00000000100000,
		PH_ACK_HIGH  = 14'b00000001000000,
		PH_RSTART    = 14'b00000010000000,
		PH_RD_LOW    = 14'b00000100000000,
		PH_RD_HIGH   = 14'b00001000000000,
		PH_MACK_LOW  = 14'b00010000000000,
		PH_MACK_HIGH = 14'b00100000000000,
		PH_STOP_A    = 14'b01000000000000,
		PH_STOP_B    = 14'b10000000000000
	} phase_t;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] target_addr;
		logic [7:0] reg_offset;
		logic [7:0] wr_data;
		logic [7:0] read_count;
		logic       sda_in;
	} item_t;

	typedef struct packed {
		logic       scl;
		logic       sda_out;
		logic       busy;
		logic       rd_valid;
		logic [7:0] rd_data;
		logic       rd_last;
		logic       done;
		logic       error;
	} result_t;

endpackage

>>> hdl/i2cm_seq.sv
`timescale 1ns / 1ps

module i2cm_seq #(
	parameter int DIV_WIDTH = i2cm_pkg::DIV_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             step,
	input  i2cm_pkg::item_t                  item,
	input  logic [i2cm_pkg::CFG_WIDTH-1:0]   half_period_ticks,
	input  logic [i2cm_pkg::CFG_WIDTH-1:0]   ack_timeout,
	output i2cm_pkg::result_t                res
);
	import i2cm_pkg::*;

	localparam int CW = ((DIV_WIDTH > CFG_WIDTH) ? DIV_WIDTH : CFG_WIDTH) + 1;

	phase_t                 phase_q, phase_d;
	stage_t                 stage_q, stage_d;
	logic [7:0]             shift_reg_q, shift_reg_d;
	logic [2:0]             bit_index_q, bit_index_d;
	logic [DIV_WIDTH-1:0]   half_counter_q, half_counter_d;
	logic [15:0]            timeout_counter_q, timeout_counter_d;
	logic [7:0]             bytes_left_q, bytes_left_d;
	logic [7:0]             saved_dev_q, saved_dev_d;
	logic [7:0]             saved_reg_q, saved_reg_d;
	logic [7:0]             saved_data_q, saved_data_d;
	logic                   is_read_q, is_read_d;
	logic                   err_flag_q, err_flag_d;

	logic [CW-1:0]          hpt_min;
	logic [CW-1:0]          half_lim;
	logic [CW-1:0]          half_eff;
	logic [CW-1:0]          hc_inc;
	logic                   half_end;
	logic [DIV_WIDTH-1:0]   hc_next;
	logic [DIV_WIDTH-1:0]   hc_last;
	logic [15:0]            tmo_inc;
	logic [7:0]             rd_byte;
	logic                   nack;

	// Effective half period: zero acts as one, capped at the counter range.
	assign hpt_min  = (half_period_ticks == '0) ? CW'(1) : CW'(half_period_ticks);
	assign half_lim = CW'(1) << DIV_WIDTH;
	assign half_eff = (hpt_min > half_lim) ? half_lim : hpt_min;
	assign hc_inc   = CW'(half_counter_q) + CW'(1);
	assign half_end = (hc_inc >= half_eff);
	assign hc_next  = hc_inc[DIV_WIDTH-1:0];
	assign hc_last  = DIV_WIDTH'(half_eff - CW'(1));
	assign tmo_inc  = timeout_counter_q + 16'd1;
	assign rd_byte  = {shift_reg_q[6:0], item.sda_in};

	always_comb begin
		phase_d           = phase_q;
		stage_d           = stage_q;
		shift_reg_d       = shift_reg_q;
		bit_index_d       = bit_index_q;
		half_counter_d    = half_counter_q;
		timeout_counter_d = timeout_counter_q;
		bytes_left_d      = bytes_left_q;
		saved_dev_d       = saved_dev_q;
		saved_reg_d       = saved_reg_q;
		saved_data_d      = saved_data_q;
		is_read_d         = is_read_q;
		err_flag_d        = err_flag_q;
		res               = '0;

		// All phases but idle and the acknowledge high half share this counter update.
		if (phase_q != PH_IDLE && phase_q != PH_ACK_HIGH) begin
			half_counter_d = half_end ? '0 : hc_next;
		end

		case (phase_q)
			PH_IDLE: begin
				if (item.op == OP_WRITE || item.op == OP_READ) begin
					saved_dev_d       = item.target_addr;
					saved_reg_d       = item.reg_offset;
					saved_data_d      = item.wr_data;
					bytes_left_d      = (item.read_count == 8'd0) ? 8'd1 : item.read_count;
					is_read_d         = (item.op == OP_READ);
					stage_d           = STG_DEV;
					shift_reg_d       = item.target_addr;
					bit_index_d       = '0;
					half_counter_d    = '0;
					timeout_counter_d = '0;
					err_flag_d        = 1'b0;
					phase_d           = PH_START_A;
				end
			end
			PH_START_A: begin
				if (half_end) phase_d = PH_START_B;
			end
			PH_START_B: begin
				if (half_end) begin
					bit_index_d = '0;
					phase_d     = PH_BIT_LOW;
				end
			end
			PH_BIT_LOW: begin
				if (half_end) phase_d = PH_BIT_HIGH;
			end
			PH_BIT_HIGH: begin
				if (half_end) begin
					shift_reg_d = {shift_reg_q[6:0], 1'b0};
					if (bit_index_q == 3'd7) begin
						bit_index_d = '0;
						phase_d     = PH_ACK_LOW;
					end else begin
						bit_index_d = bit_index_q + 3'd1;
						phase_d     = PH_BIT_LOW;
					end
				end
			end
			PH_ACK_LOW: begin
				if (half_end) begin
					timeout_counter_d = '0;
					phase_d           = PH_ACK_HIGH;
				end
			end
			PH_ACK_HIGH: begin
				if (!half_end) begin
					half_counter_d = hc_next;
				end else if (!item.sda_in) begin
					// Acknowledge seen: move on to the next byte of the sequence.
					half_counter_d = '0;
					case (stage_q)
						STG_DEV: begin
							shift_reg_d = saved_reg_q;
							stage_d     = STG_REG;
							phase_d     = PH_BIT_LOW;
						end
						STG_REG: begin
							stage_d = STG_DATA;
							if (is_read_q) begin
								shift_reg_d = saved_dev_q | 8'h01;
								phase_d     = PH_RSTART;
							end else begin
								shift_reg_d = saved_data_q;
								phase_d     = PH_BIT_LOW;
							end
						end
						default: begin
							if (is_read_q) begin
								shift_reg_d = '0;
								bit_index_d = '0;
								phase_d     = PH_RD_LOW;
							end else begin
								phase_d = PH_STOP_A;
							end
						end
					endcase
				end else begin
					// SDA still high: sample again next tick until the limit.
					timeout_counter_d = tmo_inc;
					if (tmo_inc >= ack_timeout || tmo_inc == 16'd0) begin
						half_counter_d = '0;
						err_flag_d     = 1'b1;
						phase_d        = PH_STOP_A;
					end else begin
						half_counter_d = hc_last;
					end
				end
			end
			PH_RSTART: begin
				if (half_end) phase_d = PH_START_A;
			end
			PH_RD_LOW: begin
				if (half_end) phase_d = PH_RD_HIGH;
			end
			PH_RD_HIGH: begin
				if (half_end) begin
					shift_reg_d = rd_byte;
					if (bit_index_q == 3'd7) begin
						res.rd_valid = 1'b1;
						res.rd_data  = rd_byte;
						res.rd_last  = (bytes_left_q <= 8'd1);
						bit_index_d  = '0;
						phase_d      = PH_MACK_LOW;
					end else begin
						bit_index_d = bit_index_q + 3'd1;
						phase_d     = PH_RD_LOW;
					end
				end
			end
			PH_MACK_LOW: begin
				if (half_end) phase_d = PH_MACK_HIGH;
			end
			PH_MACK_HIGH: begin
				if (half_end) begin
					if (bytes_left_q <= 8'd1) begin
						bytes_left_d = '0;
						phase_d      = PH_STOP_A;
					end else begin
						bytes_left_d = bytes_left_q - 8'd1;
						shift_reg_d  = '0;
						phase_d      = PH_RD_LOW;
					end
				end
			end
			PH_STOP_A: begin
				if (half_end) phase_d = PH_STOP_B;
			end
			PH_STOP_B: begin
				if (half_end) begin
					res.done   = 1'b1;
					res.error  = err_flag_q;
					err_flag_d = 1'b0;
					phase_d    = PH_IDLE;
				end
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase

		// Bus levels follow the phase that this tick leaves behind.
		nack = (bytes_left_d <= 8'd1);
		case (phase_d)
			PH_START_B: begin
				res.scl = 1'b1; res.sda_out = 1'b0;
			end
			PH_BIT_LOW: begin
				res.scl = 1'b0; res.sda_out = shift_reg_d[7];
			end
			PH_BIT_HIGH: begin
				res.scl = 1'b1; res.sda_out = shift_reg_d[7];
			end
			PH_ACK_LOW, PH_RSTART, PH_RD_LOW: begin
				res.scl = 1'b0; res.sda_out = 1'b1;
			end
			PH_MACK_LOW: begin
				res.scl = 1'b0; res.sda_out = nack;
			end
			PH_MACK_HIGH: begin
				res.scl = 1'b1; res.sda_out = nack;
			end
			PH_STOP_A: begin
				res.scl = 1'b0; res.sda_out = 1'b0;
			end
			PH_STOP_B: begin
				res.scl = 1'b1; res.sda_out = 1'b0;
			end
			default: begin
				res.scl = 1'b1; res.sda_out = 1'b1;
			end
		endcase
		res.busy = (phase_d != PH_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q           <= PH_IDLE;
			stage_q           <= STG_DEV;
			shift_reg_q       <= '0;
			bit_index_q       <= '0;
			half_counter_q    <= '0;
			timeout_counter_q <= '0;
			bytes_left_q      <= '0;
			saved_dev_q       <= '0;
			saved_reg_q       <= '0;
			saved_data_q      <= '0;
			is_read_q         <= 1'b0;
			err_flag_q        <= 1'b0;
		end else if (step) begin
			phase_q           <= phase_d;
			stage_q           <= stage_d;
			shift_reg_q       <= shift_reg_d;
			bit_index_q       <= bit_index_d;
			half_counter_q    <= half_counter_d;
			timeout_counter_q <= timeout_counter_d;
			bytes_left_q      <= bytes_left_d;
			saved_dev_q       <= saved_dev_d;
			saved_reg_q       <= saved_reg_d;
			saved_data_q      <= saved_data_d;
			is_read_q         <= is_read_d;
			err_flag_q        <= err_flag_d;
		end
	end

`ifndef NO_ASSERTIONS
	// The bit counter only runs while a byte is being shifted.
	a_bit_index_phase: assert property (@(posedge clk) disable iff (!arst_n)
		bit_index_q != 3'd0 |-> (phase_q == PH_BIT_LOW || phase_q == PH_BIT_HIGH ||
			phase_q == PH_RD_LOW || phase_q == PH_RD_HIGH))
		else $error("bit counter nonzero outside a byte transfer");

	// A read phase always has at least one byte still owed.
	a_bytes_left_read: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_RD_LOW || phase_q == PH_RD_HIGH ||
			phase_q == PH_MACK_LOW || phase_q == PH_MACK_HIGH) |-> bytes_left_q != 8'd0)
		else $error("read phase with no bytes left");

	// A completed transaction leaves the sequencer idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.done |=> phase_q == PH_IDLE)
		else $error("sequencer not idle after done");

	// An accepted command in idle always begins with a START.
	a_cmd_start: assert property (@(posedge clk) disable iff (!arst_n)
		step && phase_q == PH_IDLE && (item.op == OP_WRITE || item.op == OP_READ)
		|=> phase_q == PH_START_A && half_counter_q == '0)
		else $error("command did not start a transaction");
`endif

endmodule

>>> hdl/i2c_master_register_access.sv
`timescale 1ns / 1ps
// A tick request is registered in stage 1 and then stepped through the sequencer into the result
// register, which drives the outputs; a full result register holds it in stage 1.
// Throughput: one tick request per clock; the input and result registers let both sides stall.
// The rate is set by the combinational next-state logic of the bus sequencer in i2cm_seq.
// Reset (arst_n low, asynchronous): sequencer idle, both stages empty, half period 4 ticks,
// acknowledge timeout 1000 samples.

module i2c_master_register_access #(
	parameter int DIV_WIDTH = i2cm_pkg::DIV_WIDTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// Configuration write port
	input  logic                                 cfg_we,
	input  logic [i2cm_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [i2cm_pkg::CFG_WIDTH-1:0]       cfg_data,
	// Tick request channel
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [1:0]                           op,
	input  logic [7:0]                           target_addr,
	input  logic [7:0]                           reg_offset,
	input  logic [7:0]                           wr_data,
	input  logic [7:0]                           read_count,
	input  logic                                 sda_in,
	// Result channel
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic                                 scl,
	output logic                                 sda_out,
	output logic                                 busy_res,
	output logic                                 rd_valid,
	output logic [7:0]                           rd_data,
	output logic                                 rd_last,
	output logic                                 done_res,
	output logic                                 error
);
	import i2cm_pkg::*;

	logic [CFG_WIDTH-1:0] half_period_q;
	logic [CFG_WIDTH-1:0] ack_timeout_q;

	item_t   item_s1;
	logic    valid_s1;
	result_t res_s2;
	logic    valid_s2;
	result_t step_res;
	logic    advance;

	// Configuration registers. The user must write only while no request is in flight; the
	// block does not enforce this and takes writes directly, with no synchronization to the
	// request stream. A new value applies from the next tick on, even mid-transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_period_q <= HALF_PERIOD_RST;
			ack_timeout_q <= ACK_TIMEOUT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_HALF_PERIOD: half_period_q <= cfg_data;
				CFG_ACK_TIMEOUT: ack_timeout_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// The request in stage 1 is stepped through the sequencer when the result
	// register is empty or is being drained in the same cycle.
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= '{op: op, target_addr: target_addr, reg_offset: reg_offset,
				wr_data: wr_data, read_count: read_count, sda_in: sda_in};
		end
	end

	// Bus sequencer: holds all transaction state and advances one tick per step.
	i2cm_seq #(
		.DIV_WIDTH(DIV_WIDTH)
	) u_seq (
		.clk              (clk),
		.arst_n           (arst_n),
		.step             (advance),
		.item             (item_s1),
		.half_period_ticks(half_period_q),
		.ack_timeout      (ack_timeout_q),
		.res              (step_res)
	);

	// Result register: holds a finished result until the consumer takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || out_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= step_res;
		end
	end

	assign out_valid = valid_s2;
	assign scl       = res_s2.scl;
	assign sda_out   = res_s2.sda_out;
	assign busy_res  = res_s2.busy;
	assign rd_valid  = res_s2.rd_valid;
	assign rd_data   = res_s2.rd_data;
	assign rd_last   = res_s2.rd_last;
	assign done_res  = res_s2.done;
	assign error     = res_s2.error;

endmodule

>>> sim/tb_i2c_master_register_access.sv
`timescale 1ns / 1ps

module tb_i2c_master_register_access;

	import i2cm_pkg::*;

	// The run ends here even if the sequencer or the handshake hangs.
	localparam int CYCLE_LIMIT = 400000;
	localparam int DIV_W = DIV_WIDTH_DEF;
	localparam int ITEM_TARGET = 1850;

	// Every block input starts at a known value.
	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       cfg_we = 1'b0;
	logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
	logic [CFG_WIDTH-1:0]       cfg_data = '0;
	logic                       in_valid = 1'b0;
	logic                       in_ready;
	logic [1:0]                 op = '0;
	logic [7:0]                 target_addr = '0;
	logic [7:0]                 reg_offset = '0;
	logic [7:0]                 wr_data = '0;
	logic [7:0]                 read_count = '0;
	logic                       sda_in = 1'b1;
	logic                       out_valid;
	logic                       out_ready = 1'b0;
	logic                       scl;
	logic                       sda_out;
	logic                       busy_res;
	logic                       rd_valid;
	logic [7:0]                 rd_data;
	logic                       rd_last;
	logic                       done_res;
	logic                       error;

	i2c_master_register_access dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.op          (op),
		.target_addr (target_addr),
		.reg_offset  (reg_offset),
		.wr_data     (wr_data),
		.read_count  (read_count),
		.sda_in      (sda_in),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.scl         (scl),
		.sda_out     (sda_out),
		.busy_res    (busy_res),
		.rd_valid    (rd_valid),
		.rd_data     (rd_data),
		.rd_last     (rd_last),
		.done_res    (done_res),
		.error       (error)
	);

	always #5 clk = ~clk;

	// Tick requests waiting to be driven, and the bus results predicted for the
	// requests that the block has already accepted, oldest first.
	item_t   tick_req_q[$];
	result_t bus_result_q[$];

	item_t cur_req;
	bit    req_loaded = 1'b0;
	int    stall_pct = 16;
	int    fail_count = 0;
	int    ticks_queued = 0;
	int    ticks_sent = 0;
	int    writes_started = 0;
	int    reads_started = 0;
	int    bytes_read = 0;
	int    txns_done = 0;
	int    ack_timeouts = 0;
	int    cycle_count = 0;

	// Shadow of the bus sequencer. It is stepped once per accepted tick request and
	// sees the configuration registers exactly as the block does.
	phase_t            ph;
	stage_t            stg;
	logic [7:0]        shreg;
	logic [7:0]        sv_dev;
	logic [7:0]        sv_reg;
	logic [7:0]        sv_data;
	logic [7:0]        left;
	logic [2:0]        bidx;
	longint unsigned   hcnt;
	logic [15:0]       tcnt;
	logic              rd_mode;
	logic              err_pending;
	logic [15:0]       half_cfg;
	logic [15:0]       tmo_cfg;

	function automatic void reset_sequencer();
		ph = PH_IDLE;
		stg = STG_DEV;
		shreg = '0;
		sv_dev = '0;
		sv_reg = '0;
		sv_data = '0;
		left = '0;
		bidx = '0;
		hcnt = 0;
		tcnt = '0;
		rd_mode = 1'b0;
		err_pending = 1'b0;
		half_cfg = HALF_PERIOD_RST;
		tmo_cfg = ACK_TIMEOUT_RST;
	endfunction

	// A zero half period counts as one tick; the counter width caps it at the top.
	function automatic longint unsigned half_len();
		longint unsigned h;
		h = half_cfg;
		if (h == 0)
			h = 1;
		if (h > (64'd1 << DIV_W))
			h = 64'd1 << DIV_W;
		return h;
	endfunction

	function automatic bit half_over();
		if (hcnt + 1 >= half_len()) begin
			hcnt = 0;
			return 1'b1;
		end
		hcnt++;
		return 1'b0;
	endfunction

	// Picks the next byte once the slave has acknowledged the current one.
	function automatic void next_byte();
		if (stg == STG_DEV) begin
			shreg = sv_reg;
			stg = STG_REG;
			ph = PH_BIT_LOW;
		end else if (stg == STG_REG) begin
			stg = STG_DATA;
			if (rd_mode) begin
				shreg = sv_dev | 8'h01;
				ph = PH_RSTART;
			end else begin
				shreg = sv_data;
				ph = PH_BIT_LOW;
			end
		end else if (rd_mode) begin
			shreg = '0;
			bidx = '0;
			ph = PH_RD_LOW;
		end else begin
			ph = PH_STOP_A;
		end
	endfunction

	function automatic result_t bus_tick(item_t t);
		result_t r;
		logic    nack;
		r = '0;
		case (ph)
			PH_IDLE: begin
				if (t.op == OP_WRITE || t.op == OP_READ) begin
					sv_dev = t.target_addr;
					sv_reg = t.reg_offset;
					sv_data = t.wr_data;
					left = (t.read_count == 0) ? 8'd1 : t.read_count;
					rd_mode = (t.op == OP_READ);
					stg = STG_DEV;
					shreg = t.target_addr;
					bidx = '0;
					hcnt = 0;
					tcnt = '0;
					err_pending = 1'b0;
					ph = PH_START_A;
					if (rd_mode)
						reads_started++;
					else
						writes_started++;
				end
			end
			PH_START_A: begin
				if (half_over())
					ph = PH_START_B;
			end
			PH_START_B: begin
				if (half_over()) begin
					bidx = '0;
					ph = PH_BIT_LOW;
				end
			end
			PH_BIT_LOW: begin
				if (half_over())
					ph = PH_BIT_HIGH;
			end
			PH_BIT_HIGH: begin
				if (half_over()) begin
					shreg = shreg << 1;
					if (bidx == 3'd7) begin
						bidx = '0;
						ph = PH_ACK_LOW;
					end else begin
						bidx++;
						ph = PH_BIT_LOW;
					end
				end
			end
			PH_ACK_LOW: begin
				if (half_over()) begin
					tcnt = '0;
					ph = PH_ACK_HIGH;
				end
			end
			PH_ACK_HIGH: begin
				// At the end of the high half SDA is sampled, and again on every
				// further tick while it stays released.
				if (hcnt + 1 >= half_len()) begin
					if (!t.sda_in) begin
						hcnt = 0;
						next_byte();
					end else begin
						tcnt = tcnt + 16'd1;
						if (tcnt >= tmo_cfg || tcnt == 0) begin
							hcnt = 0;
							err_pending = 1'b1;
							ph = PH_STOP_A;
						end else begin
							hcnt = half_len() - 1;
						end
					end
				end else begin
					hcnt++;
				end
			end
			PH_RSTART: begin
				if (half_over())
					ph = PH_START_A;
			end
			PH_RD_LOW: begin
				if (half_over())
					ph = PH_RD_HIGH;
			end
			PH_RD_HIGH: begin
				if (half_over()) begin
					shreg = {shreg[6:0], t.sda_in};
					if (bidx == 3'd7) begin
						r.rd_valid = 1'b1;
						r.rd_data = shreg;
						r.rd_last = (left <= 8'd1);
						bidx = '0;
						ph = PH_MACK_LOW;
					end else begin
						bidx++;
						ph = PH_RD_LOW;
					end
				end
			end
			PH_MACK_LOW: begin
				if (half_over())
					ph = PH_MACK_HIGH;
			end
			PH_MACK_HIGH: begin
				if (half_over()) begin
					if (left <= 8'd1) begin
						left = '0;
						ph = PH_STOP_A;
					end else begin
						left--;
						shreg = '0;
						ph = PH_RD_LOW;
					end
				end
			end
			PH_STOP_A: begin
				if (half_over())
					ph = PH_STOP_B;
			end
			PH_STOP_B: begin
				if (half_over()) begin
					r.done = 1'b1;
					r.error = err_pending;
					err_pending = 1'b0;
					ph = PH_IDLE;
				end
			end
			default: begin
				ph = PH_IDLE;
			end
		endcase

		// Line levels follow the phase that the tick has moved to.
		nack = (left <= 8'd1);
		case (ph)
			PH_START_B: begin
				r.scl = 1'b1;
				r.sda_out = 1'b0;
			end
			PH_BIT_LOW: begin
				r.scl = 1'b0;
				r.sda_out = shreg[7];
			end
			PH_BIT_HIGH: begin
				r.scl = 1'b1;
				r.sda_out = shreg[7];
			end
			PH_ACK_LOW, PH_RSTART, PH_RD_LOW: begin
				r.scl = 1'b0;
				r.sda_out = 1'b1;
			end
			PH_MACK_LOW: begin
				r.scl = 1'b0;
				r.sda_out = nack;
			end
			PH_MACK_HIGH: begin
				r.scl = 1'b1;
				r.sda_out = nack;
			end
			PH_STOP_A: begin
				r.scl = 1'b0;
				r.sda_out = 1'b0;
			end
			PH_STOP_B: begin
				r.scl = 1'b1;
				r.sda_out = 1'b0;
			end
			default: begin
				r.scl = 1'b1;
				r.sda_out = 1'b1;
			end
		endcase
		r.busy = (ph != PH_IDLE);
		return r;
	endfunction

	function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0h, got %0h", name, want, got);
			fail_count++;
		end
	endfunction

	// Request driver. The shadow sequencer is stepped at the edge where a request is
	// accepted, so its prediction is queued long before the result can come back.
	// in_valid gets a single nonblocking assignment per edge so that back-to-back
	// requests keep it high.
	always @(posedge clk) begin : request_driver
		bit next_valid;
		next_valid = in_valid;
		if (!arst_n) begin
			next_valid = 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				bus_result_q.push_back(bus_tick(cur_req));
				ticks_sent++;
				req_loaded = 1'b0;
				next_valid = 1'b0;
			end
			if (!next_valid && tick_req_q.size() > 0 && $urandom_range(99) >= stall_pct) begin
				cur_req = tick_req_q.pop_front();
				req_loaded = 1'b1;
				op <= cur_req.op;
				target_addr <= cur_req.target_addr;
				reg_offset <= cur_req.reg_offset;
				wr_data <= cur_req.wr_data;
				read_count <= cur_req.read_count;
				sda_in <= cur_req.sda_in;
				next_valid = 1'b1;
			end
		end
		in_valid <= next_valid;
	end

	// Result monitor. Each accepted result is matched against the oldest
	// prediction, and the receiver stalls at random.
	always @(posedge clk) begin : result_monitor
		result_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (bus_result_q.size() == 0) begin
					$error("result accepted with no tick request outstanding");
					fail_count++;
				end else begin
					want = bus_result_q.pop_front();
					check_field("scl", want.scl, scl);
					check_field("sda_out", want.sda_out, sda_out);
					check_field("busy_res", want.busy, busy_res);
					check_field("rd_valid", want.rd_valid, rd_valid);
					check_field("rd_data", want.rd_data, rd_data);
					check_field("rd_last", want.rd_last, rd_last);
					check_field("done_res", want.done, done_res);
					check_field("error", want.error, error);
					if (want.rd_valid)
						bytes_read++;
					if (want.done) begin
						txns_done++;
						if (want.error)
							ack_timeouts++;
					end
				end
			end
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin : watchdog
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_i2c_master_register_access failed");
			$finish;
		end
	end

	// SDA is pulled low with the given chance on each tick.
	function automatic logic sda_level(int low_pct);
		return ($urandom_range(99) >= low_pct);
	endfunction

	task automatic queue_tick(logic [1:0] o, logic [7:0] d, logic [7:0] r, logic [7:0] w,
			logic [7:0] c, logic s);
		item_t t;
		t.op = o;
		t.target_addr = d;
		t.reg_offset = r;
		t.wr_data = w;
		t.read_count = c;
		t.sda_in = s;
		tick_req_q.push_back(t);
		ticks_queued++;
	endtask

	// Plain ticks with random payload. With noise, some of them carry a random
	// command instead, which the sequencer must ignore while it is busy.
	task automatic queue_filler(int n, int low_pct, int noise_pct);
		logic [1:0] o;
		repeat (n) begin
			o = ($urandom_range(99) < noise_pct) ? 2'($urandom_range(3)) : OP_TICK;
			queue_tick(o, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
				sda_level(low_pct));
		end
	endtask

	// Ticks needed to finish a transaction at the current half period, plus room
	// for a few repeated acknowledge samples.
	function automatic int txn_ticks(bit rd, logic [7:0] cnt);
		int halves;
		int h;
		h = (half_cfg == 0) ? 1 : int'(half_cfg);
		halves = rd ? 61 + 18 * ((cnt == 0) ? 1 : int'(cnt)) : 58;
		return halves * h + 24;
	endfunction

	// A command followed by the ticks that carry it out. A length below 100 percent
	// cuts the transaction short, so the next command lands while it is still busy.
	task automatic run_txn(op_t cmd, logic [7:0] dev, logic [7:0] reg_a, logic [7:0] dat,
			logic [7:0] cnt, int low_pct, int noise_pct, int len_pct);
		queue_tick(cmd, dev, reg_a, dat, cnt, sda_level(low_pct));
		queue_filler(txn_ticks(cmd == OP_READ, cnt) * len_pct / 100, low_pct, noise_pct);
	endtask

	task automatic wait_drained();
		while (tick_req_q.size() != 0 || req_loaded || bus_result_q.size() != 0)
			@(posedge clk);
	endtask

	// Configuration is written only once every outstanding request has produced its
	// result. The sequencer itself may be in the middle of a transaction, where a
	// new value takes effect at once.
	task automatic set_reg(logic [CFG_INDEX_WIDTH-1:0] idx, logic [15:0] val);
		wait_drained();
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		if (idx == CFG_HALF_PERIOD)
			half_cfg = val;
		else
			tmo_cfg = val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin : stimulus
		int          k;
		int          pick;
		int          kind;
		logic [15:0] tmo;
		logic [7:0]  cnt;
		op_t         cmd;

		reset_sequencer();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, starting from the reset configuration. First, writes with
		// the address and data fields at their extremes and an unused op while idle.
		// After the first write the half period is shortened to keep the run brief.
		run_txn(OP_WRITE, 8'h00, 8'hFF, 8'h00, 8'h00, 100, 0, 100);
		repeat (3) queue_tick(OP_NONE, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
		set_reg(CFG_HALF_PERIOD, 16'd1);
		run_txn(OP_WRITE, 8'hFE, 8'h00, 8'hFF, 8'hFF, 100, 0, 100);
		// A burst read with a count of zero reads a single byte; the read address
		// byte has its low bit set.
		run_txn(OP_READ, 8'hFF, 8'h5A, 8'h00, 8'h00, 50, 0, 100);
		run_txn(OP_READ, 8'h00, 8'hA5, 8'hFF, 8'h01, 50, 0, 100);
		run_txn(OP_READ, 8'h3C, 8'hC3, 8'h00, 8'h03, 50, 0, 100);
		// A zero half period behaves as a single tick.
		set_reg(CFG_HALF_PERIOD, 16'd0);
		run_txn(OP_WRITE, 8'h55, 8'hAA, 8'h55, 8'h00, 70, 0, 100);
		// A zero timeout turns the first released acknowledge sample into an error;
		// a timeout of one does the same.
		set_reg(CFG_ACK_TIMEOUT, 16'd0);
		run_txn(OP_WRITE, 8'hA0, 8'h01, 8'h02, 8'h00, 0, 0, 100);
		set_reg(CFG_ACK_TIMEOUT, 16'd1);
		run_txn(OP_READ, 8'hA2, 8'h03, 8'h04, 8'h02, 30, 0, 100);
		// Commands sprinkled through a transaction are ignored while it is busy.
		set_reg(CFG_ACK_TIMEOUT, 16'd3);
		run_txn(OP_READ, 8'h7E, 8'h81, 8'h18, 8'h02, 60, 40, 100);
		// Longest half period. The sender stops partway through the first half until
		// every result is in, then the period is shortened while the bus is busy.
		set_reg(CFG_ACK_TIMEOUT, 16'd1000);
		set_reg(CFG_HALF_PERIOD, 16'hFFFF);
		queue_tick(OP_WRITE, 8'h92, 8'h6D, 8'hC6, 8'h00, 1'b0);
		queue_filler(60, 100, 0);
		wait_drained();
		set_reg(CFG_HALF_PERIOD, 16'd1);
		queue_filler(txn_ticks(1'b0, 8'h00), 100, 0);
		// Longest acknowledge timeout.
		set_reg(CFG_ACK_TIMEOUT, 16'hFFFF);
		run_txn(OP_READ, 8'hA0, 8'h10, 8'h00, 8'h02, 60, 0, 100);

		// Random part: mostly complete transactions with random content, the rest
		// cut-short transactions, weak acknowledges and bursts of random commands.
		k = 0;
		while (ticks_queued < ITEM_TARGET) begin
			if (k % 4 == 0) begin
				pick = $urandom_range(5);
				set_reg(CFG_HALF_PERIOD, (pick < 3) ? 16'd1 : (pick < 5) ? 16'd2 :
					16'($urandom_range(3, 6)));
				pick = $urandom_range(7);
				if (pick < 2)
					tmo = 16'($urandom_range(1, 4));
				else if (pick < 5)
					tmo = 16'd1000;
				else if (pick < 7)
					tmo = 16'($urandom_range(5, 40));
				else
					tmo = 16'hFFFF;
				set_reg(CFG_ACK_TIMEOUT, tmo);
			end
			// A long stretch in which neither side idles.
			stall_pct = (k >= 1 && k < 3) ? 0 : 16;
			kind = $urandom_range(99);
			cnt = ($urandom_range(9) == 0) ? 8'($urandom_range(5, 12)) : 8'($urandom_range(4));
			cmd = $urandom_range(1) ? OP_READ : OP_WRITE;
			if (kind < 70)
				run_txn(cmd, 8'($urandom), 8'($urandom), 8'($urandom), cnt,
					$urandom_range(50, 95), 5, 100);
			else if (kind < 85)
				run_txn(cmd, 8'($urandom), 8'($urandom), 8'($urandom), cnt,
					$urandom_range(10, 30), 10, $urandom_range(20, 80));
			else
				queue_filler(20, 50, 60);
			k++;
		end

		// Drain, then give the pipeline time to show any stray result.
		wait_drained();
		repeat (20) @(posedge clk);
		$display("Sent %0d tick requests: %0d register writes and %0d burst reads started, %0d bytes read.",
			ticks_sent, writes_started, reads_started, bytes_read);
		$display("%0d transactions completed, %0d of them ended by an acknowledge timeout.",
			txns_done, ack_timeouts);
		if (fail_count == 0)
			$display("tb_i2c_master_register_access passed");
		else
			$display("tb_i2c_master_register_access failed");
		$finish;
	end

endmodule
